// ===== src/bsp_point_leaf_locator_core_macros.svh =====
// Assertion helpers shared by the locator RTL.
// Each macro takes a label, the clock, the active-low reset, the checked term and a message.
`ifndef BSP_POINT_LEAF_LOCATOR_CORE_MACROS_SVH
`define BSP_POINT_LEAF_LOCATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Property holds at every edge out of reset.
`define BSPLL_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// Expression is never true out of reset.
`define BSPLL_ASSERT_NEVER(lbl, clk_s, rst_s, expr, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(expr)) else $error(msg);

`else

`define BSPLL_ASSERT(lbl, clk_s, rst_s, prop, msg)

`define BSPLL_ASSERT_NEVER(lbl, clk_s, rst_s, expr, msg)

`endif

`endif

// ===== src/bspll_pkg.sv =====
`default_nettype none

package bspll_pkg;

  localparam int OP_W       = 2;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [OP_W-1:0] {
    OP_NODE   = 2'd0,
    OP_PLANE  = 2'd1,
    OP_LOCATE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ROOT  = 2'd0,
    REG_QOFF  = 2'd1,
    REG_LIMIT = 2'd2,
    REG_SPARE = 2'd3
  } cfg_reg_t;

  // controller -> datapath
  typedef struct packed {
    logic       wr_node;
    logic       wr_plane;
    logic       start;
    logic       node_rd;
    logic       plane_rd;
    logic       axial_step;
    logic       mac_init;
    logic       mac_step;
    logic [1:0] mac_sel;
    logic       dot_step;
    logic       load_out;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cur_neg;
    logic step_hit;
    logic kind_axial;
    logic out_busy;
  } ctrl_sts_t;

endpackage

`default_nettype wire

// ===== src/bspll_ram.sv =====
`default_nettype none

module bspll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/bspll_ctrl.sv =====
`default_nettype none

module bspll_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  input  wire logic [bspll_pkg::OP_W-1:0]  in_op,
  output logic                             in_tready,
  output bspll_pkg::ctrl_cmd_t             cmd,
  input  wire bspll_pkg::ctrl_sts_t        sts
);

  import bspll_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CHECK  = 7'b0000010,
    S_NODE   = 7'b0000100,
    S_PLANE  = 7'b0001000,
    S_MAC    = 7'b0010000,
    S_DECIDE = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] sel_r, sel_nxt;
  logic       accept;
  op_t        op;

  assign op        = op_t'(in_op);
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    cmd       = '0;
    cmd.mac_sel = sel_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_NODE:   cmd.wr_node  = 1'b1;
            OP_PLANE:  cmd.wr_plane = 1'b1;
            OP_LOCATE: begin
              cmd.start = 1'b1;
              state_nxt = S_CHECK;
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        if (sts.cur_neg || sts.step_hit) begin
          state_nxt = S_DONE;
        end else begin
          cmd.node_rd = 1'b1;
          state_nxt   = S_NODE;
        end
      end
      S_NODE: begin
        cmd.plane_rd = 1'b1;
        state_nxt    = S_PLANE;
      end
      S_PLANE: begin
        if (sts.kind_axial) begin
          cmd.axial_step = 1'b1;
          state_nxt      = S_CHECK;
        end else begin
          cmd.mac_init = 1'b1;
          sel_nxt      = 2'd0;
          state_nxt    = S_MAC;
        end
      end
      S_MAC: begin
        cmd.mac_step = 1'b1;
        if (sel_r == 2'd2) begin
          state_nxt = S_DECIDE;
        end else begin
          sel_nxt = sel_r + 2'd1;
        end
      end
      S_DECIDE: begin
        cmd.dot_step = 1'b1;
        state_nxt    = S_CHECK;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/bspll_dp.sv =====
`default_nettype none
`include "bsp_point_leaf_locator_core_macros.svh"

module bspll_dp #(
  parameter int NODE_COUNT  = 4096,
  parameter int PLANE_COUNT = 4096,
  parameter int LEAF_COUNT  = 4096
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [bspll_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [bspll_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic        [11:0]                in_entry_index,
  input  wire logic        [11:0]                in_node_plane,
  input  wire logic signed [12:0]                in_child_front,
  input  wire logic signed [12:0]                in_child_back,
  input  wire logic        [2:0]                 in_plane_kind,
  input  wire logic signed [23:0]                in_vec_x,
  input  wire logic signed [23:0]                in_vec_y,
  input  wire logic signed [23:0]                in_vec_z,
  input  wire logic signed [23:0]                in_plane_offset,
  input  wire bspll_pkg::ctrl_cmd_t              cmd,
  output bspll_pkg::ctrl_sts_t                   sts,
  input  wire logic                              out_tready,
  output logic                                   out_tvalid,
  output logic             [11:0]                out_leaf_index,
  output logic                                   out_walk_status
);

  import bspll_pkg::*;

  localparam int NAW = $clog2(NODE_COUNT);
  localparam int PAW = $clog2(PLANE_COUNT);
  localparam logic [31:0] LEAF_LAST = 32'(LEAF_COUNT - 1);

  function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
    if (v > 24'sd32767)       return 16'sd32767;
    else if (v < -24'sd32768) return -16'sd32768;
    else                      return v[15:0];
  endfunction

  // config
  logic        [11:0] root_r;
  logic signed [23:0] qoff_r;
  logic        [12:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r  <= '0;
      qoff_r  <= '0;
      limit_r <= 13'd4096;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_ROOT:  root_r  <= cfg_wdata[11:0];
        REG_QOFF:  qoff_r  <= cfg_wdata[23:0];
        REG_LIMIT: limit_r <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  // walk state
  logic signed [23:0] px_r, py_r, pz_r;
  logic signed [12:0] cur_r;
  logic        [12:0] steps_r;
  logic               node_oob_r, plane_oob_r;
  logic signed [42:0] acc_r;

  // table write side
  logic [15:0] widx16;
  logic        wnode_ok, wplane_ok;

  assign widx16    = {4'd0, in_entry_index};
  assign wnode_ok  = ({20'd0, in_entry_index} < 32'(NODE_COUNT));
  assign wplane_ok = ({20'd0, in_entry_index} < 32'(PLANE_COUNT));

  // node read side
  logic [15:0]  cur16;
  logic         cur_oob;
  logic [37:0]  node_q;
  logic [47:0]  norm_q;
  logic [26:0]  info_q;

  assign cur16   = {3'd0, cur_r};
  assign cur_oob = ({19'd0, cur_r} >= 32'(NODE_COUNT));

  bspll_ram #(.WIDTH(38), .DEPTH(NODE_COUNT)) u_node_ram (
    .clk   (clk),
    .we    (cmd.wr_node && wnode_ok),
    .waddr (widx16[NAW-1:0]),
    .wdata ({in_child_back, in_child_front, in_node_plane}),
    .re    (cmd.node_rd),
    .raddr (cur16[NAW-1:0]),
    .rdata (node_q)
  );

  // out-of-range node reads as an all-zero entry
  logic        [11:0] plane_e;
  logic signed [12:0] front_e, back_e;
  logic        [15:0] plane16;
  logic               plane_idx_oob;

  assign plane_e       = node_oob_r ? 12'd0 : node_q[11:0];
  assign front_e       = node_oob_r ? 13'sd0 : node_q[24:12];
  assign back_e        = node_oob_r ? 13'sd0 : node_q[37:25];
  assign plane16       = {4'd0, plane_e};
  assign plane_idx_oob = ({20'd0, plane_e} >= 32'(PLANE_COUNT));

  bspll_ram #(.WIDTH(48), .DEPTH(PLANE_COUNT)) u_norm_ram (
    .clk   (clk),
    .we    (cmd.wr_plane && wplane_ok),
    .waddr (widx16[PAW-1:0]),
    .wdata ({sat16(in_vec_z), sat16(in_vec_y), sat16(in_vec_x)}),
    .re    (cmd.plane_rd),
    .raddr (plane16[PAW-1:0]),
    .rdata (norm_q)
  );

  bspll_ram #(.WIDTH(27), .DEPTH(PLANE_COUNT)) u_info_ram (
    .clk   (clk),
    .we    (cmd.wr_plane && wplane_ok),
    .waddr (widx16[PAW-1:0]),
    .wdata ({in_plane_offset, in_plane_kind}),
    .re    (cmd.plane_rd),
    .raddr (plane16[PAW-1:0]),
    .rdata (info_q)
  );

  // plane fields, zero when the index was past the table
  logic        [2:0]  kind_e;
  logic signed [23:0] poff_e;
  logic signed [15:0] nx_e, ny_e, nz_e;
  logic               kind_axial;

  assign kind_e     = plane_oob_r ? 3'd0 : info_q[2:0];
  assign poff_e     = plane_oob_r ? 24'sd0 : info_q[26:3];
  assign nx_e       = plane_oob_r ? 16'sd0 : norm_q[15:0];
  assign ny_e       = plane_oob_r ? 16'sd0 : norm_q[31:16];
  assign nz_e       = plane_oob_r ? 16'sd0 : norm_q[47:32];
  assign kind_axial = (kind_e <= 3'd2);

  // axial test: coordinate - plane offset - query offset
  logic signed [23:0] p_ax;
  logic signed [25:0] dist_ax;

  always_comb begin
    case (kind_e[1:0])
      2'd0:    p_ax = px_r;
      2'd1:    p_ax = py_r;
      default: p_ax = pz_r;
    endcase
  end

  assign dist_ax = {{2{p_ax[23]}}, p_ax} - {{2{poff_e[23]}}, poff_e}
                 - {{2{qoff_r[23]}}, qoff_r};

  // general test: one shared 16x24 multiplier, three passes
  logic signed [15:0] n_sel;
  logic signed [23:0] p_sel;
  logic signed [39:0] prod;
  logic signed [24:0] d_sum;
  logic signed [42:0] d_scaled;

  always_comb begin
    case (cmd.mac_sel)
      2'd0: begin
        n_sel = nx_e;
        p_sel = px_r;
      end
      2'd1: begin
        n_sel = ny_e;
        p_sel = py_r;
      end
      default: begin
        n_sel = nz_e;
        p_sel = pz_r;
      end
    endcase
  end

  assign prod     = n_sel * p_sel;
  assign d_sum    = {poff_e[23], poff_e} + {qoff_r[23], qoff_r};
  assign d_scaled = {{4{d_sum[24]}}, d_sum, 14'd0};

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      px_r <= in_vec_x;
      py_r <= in_vec_y;
      pz_r <= in_vec_z;
    end
    if (cmd.mac_init) begin
      acc_r <= -d_scaled;
    end else if (cmd.mac_step) begin
      acc_r <= acc_r + {{3{prod[39]}}, prod};
    end
    if (cmd.node_rd) begin
      node_oob_r <= cur_oob;
    end
    if (cmd.plane_rd) begin
      plane_oob_r <= plane_idx_oob;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= '0;
      steps_r <= '0;
    end else begin
      if (cmd.start) begin
        cur_r   <= {1'b0, root_r};
        steps_r <= '0;
      end else begin
        if (cmd.node_rd) begin
          steps_r <= steps_r + 13'd1;
        end
        if (cmd.axial_step) begin
          cur_r <= dist_ax[25] ? back_e : front_e;
        end else if (cmd.dot_step) begin
          cur_r <= acc_r[42] ? back_e : front_e;
        end
      end
    end
  end

  // result register
  logic [12:0] leaf13;
  logic [11:0] leaf_clip;
  logic        step_hit;

  assign leaf13    = ~cur_r;
  assign leaf_clip = ({19'd0, leaf13} >= 32'(LEAF_COUNT)) ? LEAF_LAST[11:0] : leaf13[11:0];
  assign step_hit  = (steps_r >= limit_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_leaf_index  <= cur_r[12] ? leaf_clip : 12'd0;
      out_walk_status <= !cur_r[12];
    end
  end

  always_comb begin
    sts.cur_neg    = cur_r[12];
    sts.step_hit   = step_hit;
    sts.kind_axial = kind_axial;
    sts.out_busy   = out_tvalid && !out_tready;
  end

  `BSPLL_ASSERT(a_mac_general, clk, rst_n, cmd.mac_step |-> !kind_axial, "mac on axial plane")
  `BSPLL_ASSERT(a_steps_bound, clk, rst_n, cmd.node_rd |=> (steps_r <= limit_r), "steps past limit")
  `BSPLL_ASSERT(a_load_reason, clk, rst_n, cmd.load_out |-> (cur_r[12] || step_hit), "early load")

endmodule

`default_nettype wire

// ===== src/bsp_point_leaf_locator_core.sv =====
// BSP point-to-leaf locator.
// Input stream (in_*): one transfer per item, in_tuser carries the op.
//   op 0 loads a node entry, op 1 loads a plane entry, op 2 locates a point,
//   op 3 is dropped. Table loads are written as they are accepted and give no result.
// Output stream (out_*): one transfer per locate, leaf index in out_tdata,
//   walk status in out_tuser (1 = step limit hit, leaf reads 0).
// Locate walk, per node: the node read, the plane read, then for a general
//   node the shared multiplier, which takes the three dot-product terms one
//   per cycle before the side is chosen. One item is in work at
//   a time; in_tready is high only between items.
// Config (cfg_*): write-only; write it between items.
// Reset: rst_n, synchronous, clears the controller, walk counters and the
//   output valid; config returns to root 0, offset 0, step limit 4096.
//   Tables are not cleared: read only entries that were loaded.
// Stall: a finished result sits in the output register until taken; the
//   walk holds in its final state until that register frees up.
`default_nettype none

module bsp_point_leaf_locator_core #(
  parameter int NODE_COUNT  = 4096,
  parameter int PLANE_COUNT = 4096,
  parameter int LEAF_COUNT  = 4096
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [bspll_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [bspll_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // entry_index, node_plane, child_front, child_back, plane_kind,
  // vec_x, vec_y, vec_z, plane_offset, zero pad
  input  wire logic [151:0]                      in_tdata,
  // op
  input  wire logic [bspll_pkg::OP_W-1:0]        in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // leaf_index, zero pad
  output logic [15:0]                            out_tdata,
  // walk_status
  output logic [0:0]                             out_tuser
);

  import bspll_pkg::*;

  ctrl_cmd_t   cmd;
  ctrl_sts_t   sts;
  logic [11:0] leaf_index;
  logic        walk_status;

  bspll_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  bspll_dp #(
    .NODE_COUNT  (NODE_COUNT),
    .PLANE_COUNT (PLANE_COUNT),
    .LEAF_COUNT  (LEAF_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .in_entry_index  (in_tdata[11:0]),
    .in_node_plane   (in_tdata[23:12]),
    .in_child_front  (in_tdata[36:24]),
    .in_child_back   (in_tdata[49:37]),
    .in_plane_kind   (in_tdata[52:50]),
    .in_vec_x        (in_tdata[76:53]),
    .in_vec_y        (in_tdata[100:77]),
    .in_vec_z        (in_tdata[124:101]),
    .in_plane_offset (in_tdata[148:125]),
    .cmd             (cmd),
    .sts             (sts),
    .out_tready      (out_tready),
    .out_tvalid      (out_tvalid),
    .out_leaf_index  (leaf_index),
    .out_walk_status (walk_status)
  );

  assign out_tdata = {4'd0, leaf_index};
  assign out_tuser = walk_status;

endmodule

`default_nettype wire
